FILE: design/irnq_pkg.sv
// Package for the in-order receiver with NACK queue: beat structs,
// action codes and default sizes. No dependencies.
package irnq_pkg;

  localparam int SEQ_W       = 32;
  localparam int CAP_W       = 5;
  localparam int ACT_W       = 3;
  localparam int OCC_W       = 5;
  localparam int QUEUE_DEPTH = 16;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd10;
  localparam logic [SEQ_W-1:0] NACK_RESET = '1;

  // request types
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // result actions
  localparam logic [ACT_W-1:0] ACT_DELIVERED = 3'd0;
  localparam logic [ACT_W-1:0] ACT_QUEUED    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FULL_DROP = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GAP_DROP  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DUP_DROP  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DEQUEUED  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_IDLE_TICK = 3'd6;

  typedef struct packed {
    logic             req_type;
    logic [SEQ_W-1:0] seq_num;
    logic             channel_free;
  } in_beat_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [SEQ_W-1:0] out_seq;
    logic             feedback_valid;
    logic [SEQ_W-1:0] feedback_seq;
    logic             feedback_congestion;
    logic [OCC_W-1:0] occupancy;
    logic             schedule_tick;
  } out_beat_t;

endpackage

FILE: design/in_order_receiver_with_nack_queue.sv
// Top level of the go-back-N receiver with delivery queue and NACK feedback.
// Depends on irnq_pkg and irnq_ram.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+-----------------------------------
//  input   | start, busy, in_data          | beat taken when start && !busy
//  result  | out_valid, out_data           | one-cycle strobe, cannot stall
//  config  | cfg_valid, cfg_ready, cfg_data| write when cfg_valid && cfg_ready
//
// One beat per cycle; each result appears on the cycle after its input beat.
// Queue entries live in a RAM read at the head pointer at the input edge, so a
// popped value shows up together with its result; busy therefore stays low.
// Synchronous active-low reset clears pointers, counters, expected number and
// NACK marker; the RAM needs no clearing since only counted entries are read.
module in_order_receiver_with_nack_queue #(
  parameter int QUEUE_DEPTH = irnq_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  irnq_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  output irnq_pkg::out_beat_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irnq_pkg::CAP_W-1:0]      cfg_data
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);     // count holds QUEUE_DEPTH
  localparam int CAPW = (CW > irnq_pkg::CAP_W) ? CW : irnq_pkg::CAP_W;
  localparam int PW   = CAPW + 3;                    // room for 5x and 4x
  localparam logic [AW-1:0]   LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CAPW-1:0] DEPTH_C  = CAPW'(QUEUE_DEPTH);

  localparam int SW = irnq_pkg::SEQ_W;

  // architectural state
  logic [irnq_pkg::CAP_W-1:0] cap_r;
  logic [SW-1:0]              exp_r, exp_nxt;
  logic [SW-1:0]              nack_r, nack_nxt;
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       tick_r, tick_nxt;

  // result stage
  logic                       out_valid_r;
  logic                       pop_r, pop_nxt;
  irnq_pkg::out_beat_t        res_r, res_nxt;

  logic                       accept;
  logic                       ram_we;
  logic [SW-1:0]              ram_rdata;
  logic [CAPW-1:0]            cap_ext, cap_eff;
  logic [PW-1:0]              occ_x5, cap_x4;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // effective capacity: never above the physical depth
  assign cap_ext = CAPW'(cap_r);
  assign cap_eff = (cap_ext < DEPTH_C) ? cap_ext : DEPTH_C;

  // congestion test uses occupancy after the update
  assign occ_x5 = (PW'(count_nxt) << 2) + PW'(count_nxt);
  assign cap_x4 = PW'(cap_eff) << 2;

  always_comb begin
    exp_nxt   = exp_r;
    nack_nxt  = nack_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    tick_nxt  = tick_r;
    pop_nxt   = 1'b0;
    ram_we    = 1'b0;
    res_nxt   = '0;

    if (in_data.req_type == irnq_pkg::REQ_TICK) begin
      if (count_r != '0) begin
        res_nxt.action = irnq_pkg::ACT_DEQUEUED;
        pop_nxt        = 1'b1;
        head_nxt       = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
        count_nxt      = count_r - CW'(1);
      end else begin
        res_nxt.action = irnq_pkg::ACT_IDLE_TICK;
      end
      tick_nxt              = (count_nxt != '0);
      res_nxt.schedule_tick = tick_nxt;
    end else if (in_data.seq_num == exp_r) begin
      res_nxt.out_seq = in_data.seq_num;
      exp_nxt         = exp_r + SW'(1);
      if (in_data.channel_free) begin
        res_nxt.action = irnq_pkg::ACT_DELIVERED;
      end else if (CAPW'(count_r) >= cap_eff) begin
        res_nxt.action = irnq_pkg::ACT_FULL_DROP;
      end else begin
        res_nxt.action = irnq_pkg::ACT_QUEUED;
        ram_we         = 1'b1;
        tail_nxt       = (tail_r == LAST_IDX) ? '0 : tail_r + AW'(1);
        count_nxt      = count_r + CW'(1);
        if (!tick_r) begin
          tick_nxt              = 1'b1;
          res_nxt.schedule_tick = 1'b1;
        end
      end
      if (occ_x5 >= cap_x4) begin
        res_nxt.feedback_valid      = 1'b1;
        res_nxt.feedback_seq        = exp_nxt;
        res_nxt.feedback_congestion = 1'b1;
      end
    end else if (in_data.seq_num > exp_r) begin
      // gap: one loss NACK per expected number
      res_nxt.action  = irnq_pkg::ACT_GAP_DROP;
      res_nxt.out_seq = in_data.seq_num;
      if (nack_r != exp_r) begin
        res_nxt.feedback_valid = 1'b1;
        res_nxt.feedback_seq   = exp_r;
        nack_nxt               = exp_r;
      end
    end else begin
      res_nxt.action  = irnq_pkg::ACT_DUP_DROP;
      res_nxt.out_seq = in_data.seq_num;
    end

    res_nxt.occupancy = irnq_pkg::OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= irnq_pkg::CAP_RESET;
      exp_r       <= '0;
      nack_r      <= irnq_pkg::NACK_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      tick_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pop_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      out_valid_r <= accept;
      if (accept) begin
        exp_r   <= exp_nxt;
        nack_r  <= nack_nxt;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
        tick_r  <= tick_nxt;
        pop_r   <= pop_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  // queue store: written at tail on enqueue, read at head every cycle;
  // a pop at the input edge registers the head entry along with its result
  irnq_ram #(
    .WIDTH (SW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (tail_r),
    .wdata (in_data.seq_num),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_data = res_r;
    if (pop_r) begin
      out_data.out_seq = ram_rdata;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/irnq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module irnq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/irnq_checker.sv
// Port-level checker for the in-order receiver, bound to the top level.
// Depends on irnq_pkg and in_order_receiver_with_nack_queue.
module irnq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input irnq_pkg::out_beat_t out_data
);

  // every accepted beat gives exactly one result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted beat without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without accepted beat");

  // congestion feedback only follows an accepted data beat
  a_cong_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.feedback_valid && out_data.feedback_congestion) |->
    (out_data.action == irnq_pkg::ACT_DELIVERED ||
     out_data.action == irnq_pkg::ACT_QUEUED ||
     out_data.action == irnq_pkg::ACT_FULL_DROP))
    else $error("congestion feedback on wrong action");

  // idle tick means an empty queue and no further tick
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action == irnq_pkg::ACT_IDLE_TICK) |->
    (out_data.occupancy == '0 && !out_data.schedule_tick && !out_data.feedback_valid))
    else $error("idle tick with queued data");

  // unused feedback fields read as zero
  a_fb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.feedback_valid) |->
    (out_data.feedback_seq == '0 && !out_data.feedback_congestion))
    else $error("stale feedback fields");

endmodule

bind in_order_receiver_with_nack_queue irnq_checker u_irnq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

FILE: tb/irnq_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the in-order receiver: tracks receiver state from accepted
// input and config beats, predicts each result and compares it. Needs irnq_pkg.
module irnq_result_checker #(
  parameter int DEPTH = irnq_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  irnq_pkg::in_beat_t         in_data,
  input  logic                       out_valid,
  input  irnq_pkg::out_beat_t        out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [irnq_pkg::CAP_W-1:0] cfg_data,
  output int                         fail_cnt,
  output int                         pending_cnt,
  output int                         checked_cnt,
  output int                         feedback_cnt
);

  localparam int SW = irnq_pkg::SEQ_W;
  localparam int OW = irnq_pkg::OCC_W;

  // receiver state as predicted
  logic [irnq_pkg::CAP_W-1:0] capacity;
  logic [SW-1:0]              next_expected;
  logic [SW-1:0]              nack_marker;
  logic [SW-1:0]              fifo_mem [DEPTH];
  int                         rd_ptr;
  int                         wr_ptr;
  int                         fill;
  logic                       tick_armed;

  irnq_pkg::out_beat_t        outstanding_q [$];
  int                         errors;
  int                         checked;
  int                         feedbacks;

  function automatic irnq_pkg::out_beat_t receive_beat(irnq_pkg::in_beat_t b);
    irnq_pkg::out_beat_t r;
    int                  lim;
    r   = '0;
    lim = (capacity < DEPTH) ? int'(capacity) : DEPTH;
    if (b.req_type == irnq_pkg::REQ_TICK) begin
      if (fill > 0) begin
        r.action  = irnq_pkg::ACT_DEQUEUED;
        r.out_seq = fifo_mem[rd_ptr];
        rd_ptr    = (rd_ptr + 1) % DEPTH;
        fill--;
      end else begin
        r.action = irnq_pkg::ACT_IDLE_TICK;
      end
      tick_armed      = (fill > 0);
      r.schedule_tick = tick_armed;
    end else if (b.seq_num == next_expected) begin
      r.out_seq     = b.seq_num;
      next_expected = next_expected + 1'b1;
      if (b.channel_free) begin
        r.action = irnq_pkg::ACT_DELIVERED;
      end else if (fill >= lim) begin
        r.action = irnq_pkg::ACT_FULL_DROP;
      end else begin
        r.action         = irnq_pkg::ACT_QUEUED;
        fifo_mem[wr_ptr] = b.seq_num;
        wr_ptr           = (wr_ptr + 1) % DEPTH;
        fill++;
        if (!tick_armed) begin
          tick_armed      = 1'b1;
          r.schedule_tick = 1'b1;
        end
      end
      // congestion at 80 % of the effective capacity
      if (fill * 5 >= lim * 4) begin
        r.feedback_valid      = 1'b1;
        r.feedback_seq        = next_expected;
        r.feedback_congestion = 1'b1;
      end
    end else if (b.seq_num > next_expected) begin
      r.action  = irnq_pkg::ACT_GAP_DROP;
      r.out_seq = b.seq_num;
      if (nack_marker != next_expected) begin
        r.feedback_valid = 1'b1;
        r.feedback_seq   = next_expected;
        nack_marker      = next_expected;
      end
    end else begin
      r.action  = irnq_pkg::ACT_DUP_DROP;
      r.out_seq = b.seq_num;
    end
    r.occupancy = OW'(fill);
    return r;
  endfunction

  task automatic check_field(input string fld, input logic [SW-1:0] want,
                             input logic [SW-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, want, got);
    end
  endtask

  always @(posedge clk) begin
    irnq_pkg::out_beat_t want;
    if (!rst_n) begin
      capacity      = irnq_pkg::CAP_RESET;
      next_expected = '0;
      nack_marker   = irnq_pkg::NACK_RESET;
      rd_ptr        = 0;
      wr_ptr        = 0;
      fill          = 0;
      tick_armed    = 1'b0;
      outstanding_q.delete();
    end else begin
      // a result always belongs to an earlier beat, so compare before pushing
      if (out_valid) begin
        if (outstanding_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing outstanding, action %0d seq %0h",
                     $time, out_data.action, out_data.out_seq);
        end else begin
          want = outstanding_q.pop_front();
          check_field("action", SW'(want.action), SW'(out_data.action));
          check_field("out_seq", want.out_seq, out_data.out_seq);
          check_field("feedback_valid", SW'(want.feedback_valid),
                      SW'(out_data.feedback_valid));
          check_field("feedback_seq", want.feedback_seq, out_data.feedback_seq);
          check_field("feedback_congestion", SW'(want.feedback_congestion),
                      SW'(out_data.feedback_congestion));
          check_field("occupancy", SW'(want.occupancy), SW'(out_data.occupancy));
          check_field("schedule_tick", SW'(want.schedule_tick),
                      SW'(out_data.schedule_tick));
          checked++;
          if (want.feedback_valid) feedbacks++;
        end
      end
      // a beat taken on the same edge as a write still sees the old capacity
      if (start && !busy) outstanding_q.push_back(receive_beat(in_data));
      if (cfg_valid && cfg_ready) capacity = cfg_data;
    end
    fail_cnt     <= errors;
    pending_cnt  <= outstanding_q.size();
    checked_cnt  <= checked;
    feedback_cnt <= feedbacks;
  end

  initial begin
    errors    = 0;
    checked   = 0;
    feedbacks = 0;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the receiver testbench: clock, reset, directed and random beats,
// capacity writes, watchdog and verdict. Needs irnq_pkg and irnq_result_checker.
module tb_top;

  localparam int PHASE_BEATS = 145;   // random beats per capacity setting
  localparam int QUIET_LIMIT = 1000;  // cycles with no handshake before giving up
  localparam int SW          = irnq_pkg::SEQ_W;
  localparam int CAPW        = irnq_pkg::CAP_W;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  irnq_pkg::in_beat_t  in_data   = '0;
  logic                cfg_valid = 1'b0;
  logic [CAPW-1:0]     cfg_data  = '0;
  logic                busy;
  logic                out_valid;
  irnq_pkg::out_beat_t out_data;
  logic                cfg_ready;

  int                  fail_cnt;
  int                  pending_cnt;
  int                  checked_cnt;
  int                  feedback_cnt;

  // stimulus bookkeeping; seq_cursor mirrors the next in-order number so the
  // random part can mostly send well-formed streams
  logic [SW-1:0]       seq_cursor = '0;
  int                  beats_sent = 0;
  int                  cap_writes = 0;
  int                  quiet      = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_order_receiver_with_nack_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  irnq_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_cnt     (fail_cnt),
    .pending_cnt  (pending_cnt),
    .checked_cnt  (checked_cnt),
    .feedback_cnt (feedback_cnt)
  );

  // Watchdog: any accepted beat on any channel resets the quiet counter.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic irnq_pkg::in_beat_t data_beat(logic [SW-1:0] seq, logic free);
    irnq_pkg::in_beat_t b;
    b.req_type     = irnq_pkg::REQ_DATA;
    b.seq_num      = seq;
    b.channel_free = free;
    return b;
  endfunction

  // ticks carry random junk in the fields the receiver must ignore
  function automatic irnq_pkg::in_beat_t tick_beat();
    irnq_pkg::in_beat_t b;
    b.req_type     = irnq_pkg::REQ_TICK;
    b.seq_num      = $urandom;
    b.channel_free = 1'($urandom_range(1));
    return b;
  endfunction

  // Mostly in-order data on a busy channel so the queue fills; ticks drain
  // it; the rest is gaps, duplicates and plain noise.
  function automatic irnq_pkg::in_beat_t random_beat();
    int       pick;
    int       back;
    pick = $urandom_range(99);
    if (pick < 50) return data_beat(seq_cursor, $urandom_range(99) < 35);
    if (pick < 70) return tick_beat();
    if (pick < 82 || seq_cursor == 0) begin
      case ($urandom_range(3))
        0, 1:    return data_beat(seq_cursor + $urandom_range(1, 6),
                                  1'($urandom_range(1)));
        2:       return data_beat('1, 1'($urandom_range(1)));
        default: return data_beat($urandom, 1'($urandom_range(1)));
      endcase
    end
    if (pick < 92) begin
      back = (seq_cursor < 8) ? int'(seq_cursor) : 8;
      return data_beat(seq_cursor - $urandom_range(1, back), 1'($urandom_range(1)));
    end
    return data_beat($urandom, 1'($urandom_range(1)));
  endfunction

  // Drive one beat; optionally idle first with junk on in_data.
  task automatic send_beat(input irnq_pkg::in_beat_t b, input bit allow_gaps);
    logic [63:0] junk;
    if (allow_gaps && $urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 2)) begin
        junk = {$urandom, $urandom};
        start   <= 1'b0;
        in_data <= junk[$bits(irnq_pkg::in_beat_t)-1:0];
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    if (b.req_type == irnq_pkg::REQ_DATA && b.seq_num == seq_cursor) seq_cursor++;
    beats_sent++;
  endtask

  // Stop input, let every outstanding result land, then settle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (2) @(posedge clk);
  endtask

  // Capacity changes only on an idle receiver.
  task automatic write_capacity(input logic [CAPW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  initial begin
    logic [CAPW-1:0] phase_caps [7];
    phase_caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd0, 5'd10, 5'd31};
    phase_caps[4] = CAPW'($urandom_range(2, 15));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset capacity of 10 ---
    send_beat(tick_beat(), 1'b1);               // tick on empty queue
    send_beat(data_beat(0, 1'b1), 1'b1);        // delivered
    send_beat(data_beat(0, 1'b0), 1'b1);        // duplicate
    send_beat(data_beat('1, 1'b0), 1'b1);       // gap at max seq, first NACK
    send_beat(data_beat(7, 1'b1), 1'b1);        // gap again, NACK suppressed
    send_beat(data_beat(1, 1'b0), 1'b1);        // queued, asks for a tick
    send_beat(data_beat(2, 1'b0), 1'b1);        // queued, tick already pending
    send_beat(tick_beat(), 1'b1);               // pop, more remain
    send_beat(tick_beat(), 1'b1);               // pop, queue now empty
    send_beat(tick_beat(), 1'b1);               // idle tick
    // capacity of one: congestion on every accept, second busy accept drops
    write_capacity(5'd1);
    send_beat(data_beat(3, 1'b0), 1'b1);
    send_beat(data_beat(4, 1'b0), 1'b1);
    send_beat(data_beat(5, 1'b1), 1'b1);
    send_beat(tick_beat(), 1'b1);
    send_beat(tick_beat(), 1'b1);
    // capacity zero: busy accepts all drop, every in-order accept is congested
    write_capacity(5'd0);
    send_beat(data_beat(6, 1'b0), 1'b1);
    send_beat(data_beat(7, 1'b1), 1'b1);
    send_beat(data_beat(100, 1'b0), 1'b1);      // gap with a fresh NACK
    send_beat(data_beat(8, 1'b0), 1'b1);

    // --- random phases over several capacities; the 31 phase after 16
    // checks the clamp to queue depth and runs with no idle cycles ---
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      for (int i = 0; i < PHASE_BEATS; i++) send_beat(random_beat(), p != 1);
    end

    drain();
    repeat (2) @(posedge clk);
    $display("Sent %0d beats under %0d capacity writes (0, 1, 16, 31 and mid values).",
             beats_sent, cap_writes);
    $display("Checked %0d results, %0d of them with NACK or congestion feedback.",
             checked_cnt, feedback_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: in_order_receiver_with_nack_queue.f
design/irnq_pkg.sv
design/irnq_ram.sv
design/in_order_receiver_with_nack_queue.sv
design/irnq_checker.sv
tb/irnq_result_checker.sv
tb/tb_top.sv
